// ----- src/uks_pkg.sv -----
// uks_pkg: shared sizes, opcodes, status codes and the memory request type
// for the unique key stack
// depends on nothing
`default_nettype none

package uks_pkg;

	localparam int DEPTH      = 16;
	localparam int KEY_BITS   = 32;
	localparam int DATA_BITS  = 32;
	localparam int ADDR_BITS  = $clog2(DEPTH);
	localparam int COUNT_BITS = $clog2(DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] FULL_LEVEL = COUNT_BITS'(DEPTH);

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// one access to the key and data stores, shared address
	typedef struct packed {
		logic                        en;
		logic                        we;
		logic [ADDR_BITS-1:0]        addr;
		logic signed [KEY_BITS-1:0]  key;
		logic signed [DATA_BITS-1:0] data;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- src/uks_ram.sv -----
// uks_ram: generic single-port ram with registered read
// depends on nothing
`default_nettype none

module uks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/uks_ctrl.sv -----
// uks_ctrl: request sequencer, fill level, duplicate key scan and result registers
// depends on uks_pkg
`default_nettype none

module uks_ctrl (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [1:0]                            op,
	input  wire logic signed [uks_pkg::KEY_BITS-1:0]   push_key,
	input  wire logic signed [uks_pkg::DATA_BITS-1:0]  push_data,
	output uks_pkg::mem_req_t                          mem_req,
	input  wire logic signed [uks_pkg::KEY_BITS-1:0]   rd_key,
	input  wire logic signed [uks_pkg::DATA_BITS-1:0]  rd_data,
	output logic                                       done,
	output logic [1:0]                                 status,
	output logic signed [uks_pkg::KEY_BITS-1:0]        out_key,
	output logic signed [uks_pkg::DATA_BITS-1:0]       out_data,
	output logic [uks_pkg::COUNT_BITS-1:0]             entry_count,
	output logic                                       is_empty
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_TOP  = 3'b100
	} state_t;

	state_t                                state_q;
	logic [1:0]                            op_q;
	logic signed [uks_pkg::KEY_BITS-1:0]   key_q;
	logic signed [uks_pkg::DATA_BITS-1:0]  data_q;
	logic [uks_pkg::COUNT_BITS-1:0]        fill_q;
	logic [uks_pkg::COUNT_BITS-1:0]        scan_q;
	logic                                  pend_q;
	logic                                  done_q;
	uks_pkg::status_t                      status_q;
	logic signed [uks_pkg::KEY_BITS-1:0]   out_key_q;
	logic signed [uks_pkg::DATA_BITS-1:0]  out_data_q;
	logic [uks_pkg::COUNT_BITS-1:0]        count_q;
	logic                                  empty_q;

	logic                                  match;
	logic                                  accept;
	logic [uks_pkg::COUNT_BITS-1:0]        fill_inc;
	logic [uks_pkg::COUNT_BITS-1:0]        fill_dec;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign match    = pend_q && (rd_key == key_q);
	assign fill_inc = fill_q + uks_pkg::COUNT_BITS'(1);
	assign fill_dec = fill_q - uks_pkg::COUNT_BITS'(1);

	always_comb begin
		mem_req      = '0;
		mem_req.key  = key_q;
		mem_req.data = data_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						uks_pkg::OP_PUSH: begin
							if (fill_q == '0) begin
								mem_req.en   = 1'b1;
								mem_req.we   = 1'b1;
								mem_req.key  = push_key;
								mem_req.data = push_data;
							end
						end
						uks_pkg::OP_POP, uks_pkg::OP_PEEK: begin
							if (fill_q != '0) begin
								mem_req.en   = 1'b1;
								mem_req.addr = fill_dec[uks_pkg::ADDR_BITS-1:0];
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!match) begin
					mem_req.en = 1'b1;
					if (scan_q == fill_q) begin
						mem_req.we   = 1'b1;
						mem_req.addr = fill_q[uks_pkg::ADDR_BITS-1:0];
					end else begin
						mem_req.addr = scan_q[uks_pkg::ADDR_BITS-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							uks_pkg::OP_PUSH: begin
								if (fill_q != '0 && fill_q != uks_pkg::FULL_LEVEL) begin
									state_q <= S_SCAN;
									scan_q  <= '0;
									pend_q  <= 1'b0;
								end else begin
									done_q <= 1'b1;
									if (fill_q == '0) begin
										fill_q <= fill_inc;
									end
								end
							end
							uks_pkg::OP_POP, uks_pkg::OP_PEEK: begin
								if (fill_q != '0) begin
									state_q <= S_TOP;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (match || scan_q == fill_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						pend_q  <= 1'b0;
						if (!match) begin
							fill_q <= fill_inc;
						end
					end else begin
						scan_q <= scan_q + uks_pkg::COUNT_BITS'(1);
						pend_q <= 1'b1;
					end
				end
				S_TOP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (op_q == uks_pkg::OP_POP) begin
						fill_q <= fill_dec;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request latch and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			key_q  <= push_key;
			data_q <= push_data;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_key_q  <= '0;
					out_data_q <= '0;
					case (op)
						uks_pkg::OP_PUSH: begin
							if (fill_q == uks_pkg::FULL_LEVEL) begin
								status_q <= uks_pkg::ST_FULL;
								count_q  <= fill_q;
								empty_q  <= 1'b0;
							end else begin
								status_q <= uks_pkg::ST_OK;
								count_q  <= fill_inc;
								empty_q  <= 1'b0;
							end
						end
						uks_pkg::OP_POP, uks_pkg::OP_PEEK: begin
							status_q <= uks_pkg::ST_EMPTY;
							count_q  <= fill_q;
							empty_q  <= 1'b1;
						end
						default: begin
							status_q <= uks_pkg::ST_OK;
							count_q  <= fill_q;
							empty_q  <= (fill_q == '0);
						end
					endcase
				end
			end
			S_SCAN: begin
				out_key_q  <= '0;
				out_data_q <= '0;
				empty_q    <= 1'b0;
				if (match) begin
					status_q <= uks_pkg::ST_DUP;
					count_q  <= fill_q;
				end else begin
					status_q <= uks_pkg::ST_OK;
					count_q  <= fill_inc;
				end
			end
			S_TOP: begin
				status_q   <= uks_pkg::ST_OK;
				out_key_q  <= rd_key;
				out_data_q <= rd_data;
				if (op_q == uks_pkg::OP_POP) begin
					count_q <= fill_dec;
					empty_q <= (fill_dec == '0);
				end else begin
					count_q <= fill_q;
					empty_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_data    = out_data_q;
	assign entry_count = count_q;
	assign is_empty    = empty_q;

endmodule

`default_nettype wire

// ----- src/unique_key_stack.sv -----
// unique_key_stack: top level, sequencer plus the key and data stores
// depends on uks_pkg, uks_ram, uks_ctrl
//
// usage
// - command channel: a beat (op, push_key, push_data) is taken at a rising edge
//   with start high and busy low; busy is then high while a scan or a top read runs
// - result channel: done is high for exactly one cycle with status, out_key,
//   out_data, entry_count and is_empty; the receiver has to take it then
// - op push: full stack answers in the next cycle (status full), empty stack
//   writes at once; otherwise the stored keys are read one per cycle
//   from the single ram port and compared with the new key by one shared
//   comparator, so the block stays busy while it scans the n entries held;
//   a hit ends the scan early with status duplicate
// - op pop or peek: the top entry is read from the ram port, taken in state
//   S_TOP and registered with done; on an empty stack status empty next cycle
// - unused op code: status ok in the next cycle, stack unchanged
// - the ram port is the throughput limit: one key compared per cycle
// - a new command may be given in the cycle that done is high
// - reset empties the stack by clearing the fill level; the stores are not
//   cleared, an entry is read only below the fill level
// - the receiver cannot stall, so no result is ever held back
`default_nettype none

module unique_key_stack (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [1:0]                            op,
	input  wire logic signed [uks_pkg::KEY_BITS-1:0]   push_key,
	input  wire logic signed [uks_pkg::DATA_BITS-1:0]  push_data,
	output logic                                       done,
	output logic [1:0]                                 status,
	output logic signed [uks_pkg::KEY_BITS-1:0]        out_key,
	output logic signed [uks_pkg::DATA_BITS-1:0]       out_data,
	output logic [uks_pkg::COUNT_BITS-1:0]             entry_count,
	output logic                                       is_empty
);

	// shared access to both stores, same address for key and data
	uks_pkg::mem_req_t                    mem_req;
	logic [uks_pkg::KEY_BITS-1:0]         rd_key_raw;
	logic [uks_pkg::DATA_BITS-1:0]        rd_data_raw;
	logic signed [uks_pkg::KEY_BITS-1:0]  rd_key;
	logic signed [uks_pkg::DATA_BITS-1:0] rd_data;

	assign rd_key  = rd_key_raw;
	assign rd_data = rd_data_raw;

	// sequencer: scan counter, comparator, fill level and result registers
	uks_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.push_key    (push_key),
		.push_data   (push_data),
		.mem_req     (mem_req),
		.rd_key      (rd_key),
		.rd_data     (rd_data),
		.done        (done),
		.status      (status),
		.out_key     (out_key),
		.out_data    (out_data),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	// key store, slot 0 is the bottom of the stack
	uks_ram #(
		.WIDTH (uks_pkg::KEY_BITS),
		.DEPTH (uks_pkg::DEPTH)
	) u_key_ram (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.key),
		.rdata (rd_key_raw)
	);

	// data store, same slots as the key store
	uks_ram #(
		.WIDTH (uks_pkg::DATA_BITS),
		.DEPTH (uks_pkg::DEPTH)
	) u_data_ram (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.data),
		.rdata (rd_data_raw)
	);

endmodule

`default_nettype wire

// ----- src/uks_checker.sv -----
// uks_checker: port level assertions for unique_key_stack, bound to the top level
// depends on uks_pkg, unique_key_stack
`default_nettype none

module uks_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  busy,
	input  wire logic                                  done,
	input  wire logic [1:0]                            status,
	input  wire logic signed [uks_pkg::KEY_BITS-1:0]   out_key,
	input  wire logic signed [uks_pkg::DATA_BITS-1:0]  out_data,
	input  wire logic [uks_pkg::COUNT_BITS-1:0]        entry_count,
	input  wire logic                                  is_empty
);

	// a result beat only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// busy only rises from an accepted command beat
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command beat");

	// empty flag agrees with the count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entry_count == '0)))
		else $error("empty flag and count disagree");

	// empty answer carries no entry
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == uks_pkg::ST_EMPTY) |->
		(out_key == '0 && out_data == '0 && is_empty))
		else $error("empty status with entry fields set");

	// full answer only at the depth bound
	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == uks_pkg::ST_FULL) |-> (entry_count == uks_pkg::FULL_LEVEL))
		else $error("full status below the depth bound");

endmodule

bind unique_key_stack uks_checker u_uks_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_key     (out_key),
	.out_data    (out_data),
	.entry_count (entry_count),
	.is_empty    (is_empty)
);

`default_nettype wire

// ----- dv/stack_reply_checker.sv -----
`timescale 1ns / 1ps
// stack_reply_checker: watches the command and result channels of unique_key_stack,
// keeps a shadow copy of the stack and compares every result beat with it
// depends on uks_pkg
module stack_reply_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  busy,
	input  wire logic [1:0]                            op,
	input  wire logic signed [uks_pkg::KEY_BITS-1:0]   push_key,
	input  wire logic signed [uks_pkg::DATA_BITS-1:0]  push_data,
	input  wire logic                                  done,
	input  wire logic [1:0]                            status,
	input  wire logic signed [uks_pkg::KEY_BITS-1:0]   out_key,
	input  wire logic signed [uks_pkg::DATA_BITS-1:0]  out_data,
	input  wire logic [uks_pkg::COUNT_BITS-1:0]        entry_count,
	input  wire logic                                  is_empty,
	output int                                         failures,
	output int                                         pending,
	output int                                         replies_seen,
	output int                                         dup_refusals,
	output int                                         full_refusals,
	output int                                         empty_replies
);

	typedef struct packed {
		uks_pkg::status_t                      status;
		logic signed [uks_pkg::KEY_BITS-1:0]   key;
		logic signed [uks_pkg::DATA_BITS-1:0]  data;
		logic [uks_pkg::COUNT_BITS-1:0]        count;
		logic                                  empty;
	} stack_reply_t;

	logic signed [uks_pkg::KEY_BITS-1:0]  shadow_keys [uks_pkg::DEPTH];
	logic signed [uks_pkg::DATA_BITS-1:0] shadow_data [uks_pkg::DEPTH];
	int                                   shadow_level = 0;
	stack_reply_t                         replies_due [$];
	stack_reply_t                         want;

	initial begin
		failures = 0;
		pending = 0;
		replies_seen = 0;
		dup_refusals = 0;
		full_refusals = 0;
		empty_replies = 0;
	end

	// applies one request to the shadow stack and returns the reply it should give
	function automatic stack_reply_t stack_apply(input logic [1:0] cmd,
			input logic signed [uks_pkg::KEY_BITS-1:0] k,
			input logic signed [uks_pkg::DATA_BITS-1:0] d);
		stack_reply_t r;
		bit           seen;
		r = '0;
		r.status = uks_pkg::ST_OK;
		seen = 1'b0;
		case (cmd)
		uks_pkg::OP_PUSH: begin
			// fullness wins over the duplicate scan
			if (shadow_level >= uks_pkg::DEPTH) begin
				r.status = uks_pkg::ST_FULL;
			end else begin
				for (int i = 0; i < shadow_level; i++)
					if (shadow_keys[i] == k)
						seen = 1'b1;
				if (seen) begin
					r.status = uks_pkg::ST_DUP;
				end else begin
					shadow_keys[shadow_level] = k;
					shadow_data[shadow_level] = d;
					shadow_level++;
				end
			end
		end
		uks_pkg::OP_POP, uks_pkg::OP_PEEK: begin
			if (shadow_level == 0) begin
				r.status = uks_pkg::ST_EMPTY;
			end else begin
				r.key = shadow_keys[shadow_level-1];
				r.data = shadow_data[shadow_level-1];
				if (cmd == uks_pkg::OP_POP)
					shadow_level--;
			end
		end
		default: ;
		endcase
		r.count = uks_pkg::COUNT_BITS'(shadow_level);
		r.empty = (shadow_level == 0);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			failures++;
			$display("%0d ns: %s expected %0h, got %0h", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_level = 0;
			replies_due.delete();
			pending <= 0;
		end else begin
			if (start && !busy)
				replies_due.push_back(stack_apply(op, push_key, push_data));
			if (done) begin
				if (replies_due.size() == 0) begin
					failures++;
					$display("%0d ns: result beat with nothing expected, status %0d",
						$time, status);
				end else begin
					want = replies_due.pop_front();
					replies_seen++;
					if (want.status == uks_pkg::ST_DUP)
						dup_refusals++;
					if (want.status == uks_pkg::ST_FULL)
						full_refusals++;
					if (want.status == uks_pkg::ST_EMPTY)
						empty_replies++;
					check_field("status", 32'(want.status), 32'(status));
					check_field("out_key", want.key, out_key);
					check_field("out_data", want.data, out_data);
					check_field("entry_count", 32'(want.count), 32'(entry_count));
					check_field("is_empty", 32'(want.empty), 32'(is_empty));
				end
			end
			pending <= replies_due.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: top of the unique_key_stack test, makes the commands and gives the verdict
// depends on uks_pkg, unique_key_stack and stack_reply_checker
module testbench;

	import uks_pkg::*;

	// op code the block has to ignore
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         RANDOM_ITEMS = 1025;
	// cycles with no beat on either channel before the run is abandoned
	localparam int         STALL_LIMIT  = 1000;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  op;
	logic signed [KEY_BITS-1:0]  push_key;
	logic signed [DATA_BITS-1:0] push_data;
	logic                        done;
	logic [1:0]                  status;
	logic signed [KEY_BITS-1:0]  out_key;
	logic signed [DATA_BITS-1:0] out_data;
	logic [COUNT_BITS-1:0]       entry_count;
	logic                        is_empty;

	int failures, pending, replies_seen, dup_refusals, full_refusals, empty_replies;
	int n_push = 0, n_pop = 0, n_peek = 0, n_unused = 0;
	int stall_cycles = 0;

	// small pool of keys so that pushes hit stored keys often
	logic [31:0] key_pool [20];

	always #10 clk = ~clk;

	unique_key_stack dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.push_key    (push_key),
		.push_data   (push_data),
		.done        (done),
		.status      (status),
		.out_key     (out_key),
		.out_data    (out_data),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	// watches both channels, keeps the shadow stack, counts mismatches
	stack_reply_checker reply_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.push_key      (push_key),
		.push_data     (push_data),
		.done          (done),
		.status        (status),
		.out_key       (out_key),
		.out_data      (out_data),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.failures      (failures),
		.pending       (pending),
		.replies_seen  (replies_seen),
		.dup_refusals  (dup_refusals),
		.full_refusals (full_refusals),
		.empty_replies (empty_replies)
	);

	// present one command beat and hold it until the block takes it;
	// busy is read just after the edge, so it is the value the block saw
	task automatic send_request(input logic [1:0] cmd, input logic [31:0] k,
			input logic [31:0] d);
		start <= 1'b1;
		op <= cmd;
		push_key <= k;
		push_data <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		case (cmd)
		OP_PUSH: n_push++;
		OP_POP:  n_pop++;
		OP_PEEK: n_peek++;
		default: n_unused++;
		endcase
	endtask

	// sender idles; the payload wanders meanwhile, the block must not care
	task automatic sender_gap(input int cycles);
		start <= 1'b0;
		repeat (cycles) begin
			op <= 2'($urandom);
			push_key <= $urandom;
			push_data <= $urandom;
			@(posedge clk);
		end
	endtask

	// hold off until every outstanding result beat has come back;
	// one edge first so that the checker has seen the last command
	task automatic drain_results;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		return ($urandom_range(99) < 60) ? key_pool[$urandom_range(19)] : $urandom;
	endfunction

	// watchdog: no beat for too long means the block is hung
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int         roll;
		int         phase_left;
		bit         push_bias;
		bit         idling_on;
		logic [1:0] cmd;

		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_PUSH;
		push_key <= '0;
		push_data <= '0;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 20; i++)
			key_pool[i] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// empty stack: peek and pop report empty, unused op leaves it alone
		send_request(OP_PEEK, $urandom, $urandom);
		send_request(OP_POP, $urandom, $urandom);
		send_request(OP_UNUSED, $urandom, $urandom);
		// extreme keys and data, first push lands on an empty stack
		send_request(OP_PUSH, 32'h8000_0000, 32'h7fff_ffff);
		send_request(OP_PUSH, 32'h7fff_ffff, 32'h8000_0000);
		// key already held at the bottom: refused at the first compare
		send_request(OP_PUSH, 32'h8000_0000, 32'h1234_5678);
		send_request(OP_PEEK, $urandom, $urandom);
		send_request(OP_POP, $urandom, $urandom);
		// fill up to the depth bound with distinct keys
		send_request(OP_PUSH, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_PUSH, 32'hffff_ffff, 32'hffff_ffff);
		for (int i = 0; i < 13; i++)
			send_request(OP_PUSH, {4'(i), 28'h5a5_a5a5}, $urandom);
		// full stack: fresh key and held key are both refused as full
		send_request(OP_PUSH, 32'h0123_4567, $urandom);
		send_request(OP_PUSH, 32'h0000_0000, $urandom);
		send_request(OP_UNUSED, $urandom, $urandom);

		// random part: phases that lean towards push or towards pop, so the
		// stack swings between empty and full over and over
		push_bias = 1'b0;
		phase_left = $urandom_range(20, 60);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				push_bias = !push_bias;
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			roll = $urandom_range(99);
			if (roll < 3)
				cmd = OP_UNUSED;
			else if (roll < (push_bias ? 68 : 28))
				cmd = OP_PUSH;
			else if (roll < (push_bias ? 88 : 78))
				cmd = OP_POP;
			else
				cmd = OP_PEEK;
			// a long run with the sender never idle
			idling_on = !(n >= 400 && n < 600);
			if (n == 300 || n == 750) begin
				drain_results();
			end else if (idling_on && $urandom_range(99) < 33) begin
				// mostly short gaps, some long enough to span a whole scan
				if ($urandom_range(3) == 0)
					sender_gap($urandom_range(4, 20));
				else
					sender_gap($urandom_range(1, 3));
			end
			send_request(cmd, pick_key(), $urandom);
		end

		drain_results();
		// let any stray beat from a push scan show up before the summary
		repeat (20) @(posedge clk);

		$display("%0d requests: %0d push, %0d pop, %0d peek, %0d unused op",
			n_push + n_pop + n_peek + n_unused, n_push, n_pop, n_peek, n_unused);
		$display("%0d results checked: %0d duplicate, %0d full, %0d empty replies",
			replies_seen, dup_refusals, full_refusals, empty_replies);
		if (failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/uks_pkg.sv
src/uks_ram.sv
src/uks_ctrl.sv
src/unique_key_stack.sv
src/uks_checker.sv
dv/stack_reply_checker.sv
dv/testbench.sv
